// ===== design/ilt_pkg.sv =====
package ilt_pkg;

	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_VT     = 8'd11;
	localparam logic [7:0] CH_FF     = 8'd12;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef enum logic [3:0] {
		KIND_HEAD_CH   = 4'd0,
		KIND_KEY_CH    = 4'd1,
		KIND_LOC_CH    = 4'd2,
		KIND_VAL_CH    = 4'd3,
		KIND_HEAD_DONE = 4'd4,
		KIND_KV_DONE   = 4'd5,
		KIND_ERR_TRAIL = 4'd6,
		KIND_ERR_EQ    = 4'd7,
		KIND_ERR_BRACK = 4'd8,
		KIND_EOF       = 4'd9
	} kind_t;

	typedef enum logic [3:0] {
		PH_LSTART    = 4'd0,
		PH_COMMENT   = 4'd1,
		PH_HEAD      = 4'd2,
		PH_HEAD_TAIL = 4'd3,
		PH_KEY       = 4'd4,
		PH_KEY_WS    = 4'd5,
		PH_LOC       = 4'd6,
		PH_LOC_TAIL  = 4'd7,
		PH_VALUE     = 4'd8,
		PH_EOF       = 4'd9
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] char_out;
		logic       last;
	} token_t;

	// One accepted byte yields up to two result words; only the second
	// one's kind is needed since it never carries a character.
	typedef struct packed {
		logic [1:0] cnt;
		kind_t      kind0;
		logic [7:0] char0;
		kind_t      kind1;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t head;
	} q_head_t;

endpackage

// ===== design/ilt_front.sv =====
module ilt_front import ilt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	output logic  enq,
	output cmd_t  cmd
);

	phase_t phase_q, phase_d;
	logic   halted_q, halted_d;
	logic [7:0] c;
	logic   eoi;
	logic   is_ws;
	logic   end_err;
	kind_t  end_kind;
	logic   end_has;

	assign c   = item.byte_value;
	assign eoi = item.end_of_input;

	always_comb begin
		is_ws = c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
	end

	// Result of finishing the current line.
	always_comb begin
		end_err  = 1'b0;
		end_has  = 1'b0;
		end_kind = KIND_EOF;
		case (phase_q)
			PH_HEAD, PH_LOC: begin
				end_err  = 1'b1;
				end_has  = 1'b1;
				end_kind = KIND_ERR_BRACK;
			end
			PH_KEY, PH_KEY_WS, PH_LOC_TAIL: begin
				end_err  = 1'b1;
				end_has  = 1'b1;
				end_kind = KIND_ERR_EQ;
			end
			PH_HEAD_TAIL: begin
				end_has  = 1'b1;
				end_kind = KIND_HEAD_DONE;
			end
			PH_VALUE: begin
				end_has  = 1'b1;
				end_kind = KIND_KV_DONE;
			end
			default: begin
				end_has  = 1'b0;
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		halted_d = halted_q;
		if (accept && !halted_q) begin
			if (eoi) begin
				if (phase_q != PH_EOF) begin
					if (end_err) begin
						halted_d = 1'b1;
						phase_d  = PH_LSTART;
					end else begin
						phase_d = PH_EOF;
					end
				end
			end else if (phase_q == PH_EOF) begin
				phase_d = PH_EOF;
			end else if (c == CH_NL) begin
				phase_d  = PH_LSTART;
				halted_d = end_err;
			end else begin
				case (phase_q)
					PH_LSTART: begin
						if (is_ws)                 phase_d = PH_LSTART;
						else if (c == CH_HASH)     phase_d = PH_COMMENT;
						else if (c == CH_LBRACK)   phase_d = PH_HEAD;
						else if (c == CH_EQUALS)   phase_d = PH_VALUE;
						else                       phase_d = PH_KEY;
					end
					PH_HEAD: begin
						if (c == CH_RBRACK) phase_d = PH_HEAD_TAIL;
					end
					PH_HEAD_TAIL: begin
						if (!is_ws) halted_d = 1'b1;
					end
					PH_KEY: begin
						if (c == CH_LBRACK)      phase_d = PH_LOC;
						else if (c == CH_EQUALS) phase_d = PH_VALUE;
						else if (is_ws)          phase_d = PH_KEY_WS;
					end
					PH_KEY_WS, PH_LOC_TAIL: begin
						if (c == CH_EQUALS) phase_d = PH_VALUE;
						else if (!is_ws)    halted_d = 1'b1;
					end
					PH_LOC: begin
						if (c == CH_RBRACK) phase_d = PH_LOC_TAIL;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_comb begin
		cmd.cnt   = 2'd0;
		cmd.kind0 = KIND_EOF;
		cmd.char0 = 8'd0;
		cmd.kind1 = KIND_EOF;
		if (!halted_q) begin
			if (eoi) begin
				if (phase_q == PH_EOF) begin
					cmd.cnt = 2'd1;
				end else if (end_err) begin
					cmd.cnt   = 2'd1;
					cmd.kind0 = end_kind;
				end else if (end_has) begin
					cmd.cnt   = 2'd2;
					cmd.kind0 = end_kind;
				end else begin
					cmd.cnt = 2'd1;
				end
			end else if (phase_q == PH_EOF) begin
				cmd.cnt = 2'd0;
			end else if (c == CH_NL) begin
				cmd.cnt   = end_has ? 2'd1 : 2'd0;
				cmd.kind0 = end_kind;
			end else begin
				case (phase_q)
					PH_LSTART: begin
						if (!is_ws && c != CH_HASH && c != CH_LBRACK && c != CH_EQUALS) begin
							cmd.cnt   = 2'd1;
							cmd.kind0 = KIND_KEY_CH;
							cmd.char0 = c;
						end
					end
					PH_HEAD: begin
						if (c != CH_RBRACK) begin
							cmd.cnt   = 2'd1;
							cmd.kind0 = KIND_HEAD_CH;
							cmd.char0 = c;
						end
					end
					PH_HEAD_TAIL: begin
						if (!is_ws) begin
							cmd.cnt   = 2'd1;
							cmd.kind0 = KIND_ERR_TRAIL;
						end
					end
					PH_KEY: begin
						if (c != CH_LBRACK && c != CH_EQUALS && !is_ws) begin
							cmd.cnt   = 2'd1;
							cmd.kind0 = KIND_KEY_CH;
							cmd.char0 = c;
						end
					end
					PH_KEY_WS, PH_LOC_TAIL: begin
						if (c != CH_EQUALS && !is_ws) begin
							cmd.cnt   = 2'd1;
							cmd.kind0 = KIND_ERR_EQ;
						end
					end
					PH_LOC: begin
						if (c != CH_RBRACK) begin
							cmd.cnt   = 2'd1;
							cmd.kind0 = KIND_LOC_CH;
							cmd.char0 = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ?
								c + CASE_OFFSET : c;
						end
					end
					PH_VALUE: begin
						cmd.cnt   = 2'd1;
						cmd.kind0 = KIND_VAL_CH;
						cmd.char0 = c;
					end
					default: begin
						cmd.cnt = 2'd0;
					end
				endcase
			end
		end
	end

	assign enq = accept && (cmd.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LSTART;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ===== design/ilt_queue.sv =====
module ilt_queue import ilt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    enq,
	input  cmd_t    enq_data,
	output logic    full,
	input  logic    deq,
	output q_head_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_enq;
	logic          do_deq;

	assign full       = (cnt_q == FULL_CNT);
	assign do_enq     = enq && !full;
	assign do_deq     = deq && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem_q[wr_ptr_q] <= enq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/ilt_back.sv =====
module ilt_back import ilt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    deq,
	output logic    empty,
	input  logic    pop,
	output token_t  token
);

	logic   out_valid_q;
	token_t out_q;
	logic   idx_q;
	logic   load;
	logic   single;

	assign empty  = !out_valid_q;
	assign token  = out_q;
	assign load   = !out_valid_q || pop;
	assign single = (head.head.cnt == 2'd1);
	assign deq    = load && head.valid && (idx_q || single);

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			if (idx_q) begin
				out_q.kind     <= head.head.kind1;
				out_q.char_out <= 8'd0;
				out_q.last     <= 1'b1;
			end else begin
				out_q.kind     <= head.head.kind0;
				out_q.char_out <= head.head.char0;
				out_q.last     <= single;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= !idx_q && !single;
			end
		end
	end

endmodule

// ===== design/ini_line_tokenizer.sv =====
// Channel  | Handshake                  | Word
// ---------+----------------------------+---------------------------------
// item     | push / full, taken on      | byte_value, end_of_input
//          | push && !full              |
// token    | empty / pop, taken on      | kind, char_out, last
//          | pop && !empty              |
//
// One byte is classified and its results queued in the cycle it is taken.
// While popped, results leave one word a cycle via a registered output
// stage, so a byte giving two words (a line finished at end of input)
// yields them in turn; input keeps flowing until the result queue fills.
// Reset clears the line state, the result queue and the output stage.
// A stalled output backs up only into the queue of QUEUE_DEPTH entries.
module ini_line_tokenizer import ilt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  item,
	output logic   empty,
	input  logic   pop,
	output token_t token
);

	logic    accept;
	logic    enq;
	cmd_t    cmd;
	logic    deq;
	q_head_t head;

	assign accept = push && !full;

	ilt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.enq    (enq),
		.cmd    (cmd)
	);

	ilt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_data (cmd),
		.full     (full),
		.deq      (deq),
		.head     (head)
	);

	ilt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.deq    (deq),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

endmodule
